// ----- src/ifcu_pkg.sv -----
`timescale 1ns / 1ps

package ifcu_pkg;

    // request kinds
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    // pointers hold any slot below the largest capacity the register can name
    localparam int PTR_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

endpackage

// ----- src/ifcu_ram.sv -----
`timescale 1ns / 1ps

module ifcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/indexed_circular_fifo_unit.sv -----
`timescale 1ns / 1ps

// Indexed circular FIFO. Each request beat on the s_ side carries a mode (push, pop, read at a
// logical index from the oldest entry, overwrite at a logical index) and returns exactly one
// result beat on the m_ side with the read data (zero unless a read succeeded), a status
// (ok, full on push, empty on pop, index at or past the fill count) and the fill count after
// the request. Requests that fail are ignored apart from their status. The block takes one
// beat per cycle when the consumer keeps up and no capacity write is pending; a result passes
// through a pipe stage, waiting on the RAM's registered read, and then the output register.
// A stalled result holds one request in flight behind it and then stops the input side.
// The capacity register sets the wrap point of head and tail: a write of 0 is taken as 1 and
// a value above DEPTH as DEPTH; every capacity write empties the FIFO but keeps slot contents.
// It is taken only when no request is in flight. Slot RAM is never cleared: only entries
// pushed since the last emptying are reachable, so no clearing pass follows reset.
module indexed_circular_fifo_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // request beat: [1:0] mode, [5:2] index, [37:6] data_in, [39:38] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ifcu_pkg::S_TDATA_W-1:0] s_tdata,

    // result beat: [31:0] data_out, [33:32] status, [38:34] fill_count, [39] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ifcu_pkg::M_TDATA_W-1:0] m_tdata,

    // capacity register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ifcu_pkg::CNT_W-1:0]     cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = ifcu_pkg::PTR_W;
    localparam int CW = ifcu_pkg::CNT_W;

    // largest capacity the pointers can wrap at, and the capacity after reset
    localparam logic [CW-1:0] CAP_MAX = (DEPTH < 31) ? CW'(DEPTH) : CW'(31);
    localparam logic [CW-1:0] CAP_RST = (DEPTH < 16) ? CW'(DEPTH) : CW'(16);

    // head/tail/count state
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cap_reg, cap_next;

    // stage between request and result: waits for the RAM read data
    logic                    p_valid_reg, p_valid_next;
    logic                    p_read_reg;
    ifcu_pkg::status_t       p_status_reg;
    logic [CW-1:0]           p_cnt_reg;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [ifcu_pkg::DATA_W-1:0]         out_data_reg;
    ifcu_pkg::status_t                   out_status_reg;
    logic [CW-1:0]                       out_cnt_reg;

    // request fields
    ifcu_pkg::mode_t                     req_mode;
    logic [ifcu_pkg::INDEX_W-1:0]        req_index;
    logic [ifcu_pkg::DATA_W-1:0]         req_data;

    // per-request decode
    ifcu_pkg::status_t req_status;
    logic              req_read;
    logic              ram_we, ram_re;
    logic [PW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic s_acc, cfg_acc, p_move;
    logic [CW-1:0] cap_in;

    function automatic logic [PW-1:0] wrap_add(
        input logic [PW-1:0] base,
        input logic [PW-1:0] off,
        input logic [CW-1:0] cap
    );
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(cap)) begin
            sum = sum - (PW+1)'(cap);
        end
        return sum[PW-1:0];
    endfunction

    assign req_mode  = ifcu_pkg::mode_t'(s_tdata[1:0]);
    assign req_index = s_tdata[5:2];
    assign req_data  = s_tdata[37:6];

    // pipe stage drains when the output register is free or being taken
    assign p_move    = p_valid_reg && (!out_valid_reg || m_tready);
    // a pending capacity write holds requests off
    assign s_tready  = (!p_valid_reg || p_move) && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = !p_valid_reg && !out_valid_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // clamp the written capacity into the usable range
    always_comb begin
        cap_in = cfg_data;
        if (cfg_data == '0) begin
            cap_in = CW'(1);
        end else if (cfg_data > CAP_MAX) begin
            cap_in = CAP_MAX;
        end
    end

    // request decode and pointer update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        req_status = ifcu_pkg::ST_OK;
        req_read   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = tail_reg;
        ram_raddr  = wrap_add(head_reg, PW'(req_index), cap_reg);

        unique case (req_mode)
            ifcu_pkg::MODE_PUSH: begin
                if (cnt_reg >= cap_reg) begin
                    req_status = ifcu_pkg::ST_FULL;
                end else begin
                    ram_we    = s_acc;
                    tail_next = wrap_add(tail_reg, PW'(1), cap_reg);
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            ifcu_pkg::MODE_POP: begin
                if (cnt_reg == '0) begin
                    req_status = ifcu_pkg::ST_EMPTY;
                end else begin
                    head_next = wrap_add(head_reg, PW'(1), cap_reg);
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            ifcu_pkg::MODE_READ: begin
                if (CW'(req_index) >= cnt_reg) begin
                    req_status = ifcu_pkg::ST_RANGE;
                end else begin
                    req_read = 1'b1;
                    ram_re   = s_acc;
                end
            end
            ifcu_pkg::MODE_WRITE: begin
                if (CW'(req_index) >= cnt_reg) begin
                    req_status = ifcu_pkg::ST_RANGE;
                end else begin
                    ram_we    = s_acc;
                    ram_waddr = ram_raddr;
                end
            end
            default: begin
                req_status = ifcu_pkg::ST_OK;
            end
        endcase

        if (!s_acc) begin
            head_next = head_reg;
            tail_next = tail_reg;
            cnt_next  = cnt_reg;
        end
        // capacity write empties the fifo
        if (cfg_acc) begin
            cap_next  = cap_in;
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (s_acc) begin
            p_valid_next = 1'b1;
        end else if (p_move) begin
            p_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (p_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            cap_reg       <= CAP_RST;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p_read_reg   <= req_read;
            p_status_reg <= req_status;
            p_cnt_reg    <= cnt_next;
        end
        // ram read data is stable until the next accepted read
        if (p_move) begin
            out_data_reg   <= p_read_reg ? ifcu_pkg::DATA_W'(ram_rdata) : '0;
            out_status_reg <= p_status_reg;
            out_cnt_reg    <= p_cnt_reg;
        end
    end

    ifcu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(ram_waddr)),
        .wdata (DATA_WIDTH'(req_data)),
        .re    (ram_re),
        .raddr (AW'(ram_raddr)),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_status_reg, out_data_reg};

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= cap_reg)
        else $error("fill count above capacity");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < cap_reg && tail_reg < cap_reg)
        else $error("pointer past wrap point");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && req_mode == ifcu_pkg::MODE_PUSH && cnt_reg < cap_reg
        |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("push did not raise fill count");

    a_cfg_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> cnt_reg == '0 && head_reg == '0 && tail_reg == '0)
        else $error("capacity write did not empty fifo");
`endif

endmodule
